[rtl/lav_pkg.sv]
// ---------------------------------------------------------------------------
// lav_pkg
// Shared constants for the look-at view matrix block.
// ---------------------------------------------------------------------------
package lav_pkg;

    localparam int WORD_BITS = 32;
    localparam int FRAC_BITS = 16;

endpackage

[rtl/lav_div.sv]
// ---------------------------------------------------------------------------
// lav_div
// Pipelined restoring divider for one vector component during normalize:
// q = trunc(|v| * 2^FRAC_BITS / s) with the sign of v, saturated to a word.
// One quotient bit per stage; the sign and divisor travel with the value,
// which stalls with the rest of the pipe.
// ---------------------------------------------------------------------------
module lav_div #(
    parameter int WORD_BITS = lav_pkg::WORD_BITS,
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [WORD_BITS-1:0] i_v,
    input  logic        [WORD_BITS-1:0] i_s,
    output logic signed [WORD_BITS-1:0] o_q
);
    localparam int NB = WORD_BITS + FRAC_BITS;

    logic [NB-1:0]        r_num [NB+1];
    logic [WORD_BITS:0]   r_rem [NB+1];
    logic [NB-1:0]        r_quo [NB+1];
    logic [WORD_BITS-1:0] r_den [NB+1];
    logic                 r_neg [NB+1];
    logic [WORD_BITS-1:0] w_mag;
    logic [NB-1:0]        w_qm;

    assign w_mag = i_v[WORD_BITS-1] ? WORD_BITS'(-i_v) : WORD_BITS'(i_v);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_num[0] <= {w_mag, FRAC_BITS'(0)};
            r_rem[0] <= '0;
            r_quo[0] <= '0;
            r_den[0] <= i_s;
            r_neg[0] <= i_v[WORD_BITS-1];
        end
    end

    for (genvar k = 0; k < NB; k++) begin : g_st
        logic [WORD_BITS:0] w_t;
        logic               w_ge;
        assign w_t  = {r_rem[k][WORD_BITS-1:0], r_num[k][NB-1]};
        assign w_ge = w_t >= {1'b0, r_den[k]};
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_num[k+1] <= r_num[k] << 1;
                r_rem[k+1] <= w_ge ? w_t - {1'b0, r_den[k]} : w_t;
                r_quo[k+1] <= {r_quo[k][NB-2:0], w_ge};
                r_den[k+1] <= r_den[k];
                r_neg[k+1] <= r_neg[k];
            end
        end
    end

    assign w_qm = r_quo[NB];
    always_comb begin
        if (|w_qm[NB-1:WORD_BITS-1]) begin
            if (r_neg[NB] && w_qm == (NB'(1) << (WORD_BITS-1))) o_q = {1'b1, {(WORD_BITS-1){1'b0}}};
            else o_q = r_neg[NB] ? {1'b1, {(WORD_BITS-1){1'b0}}} : {1'b0, {(WORD_BITS-1){1'b1}}};
        end else begin
            o_q = r_neg[NB] ? -$signed(w_qm[WORD_BITS-1:0]) : $signed(w_qm[WORD_BITS-1:0]);
        end
    end
endmodule

[rtl/lav_norm.sv]
// ---------------------------------------------------------------------------
// lav_norm
// Pipelined vector normalize: squared length, bit-per-stage integer square
// root, then three pipelined dividers. Zero-length vectors pass unchanged.
// Also delays a side word (the rest of the item) alongside.
// ---------------------------------------------------------------------------
module lav_norm #(
    parameter int WORD_BITS = lav_pkg::WORD_BITS,
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS,
    parameter int SIDE_BITS = 1
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [WORD_BITS-1:0] i_v [3],
    input  logic        [SIDE_BITS-1:0] i_side,
    output logic signed [WORD_BITS-1:0] o_v [3],
    output logic        [SIDE_BITS-1:0] o_side
);
    localparam int SQ  = 2*WORD_BITS + 2;
    // divider depth: its input register plus one stage per quotient bit
    localparam int DEP = WORD_BITS + FRAC_BITS + 1;

    logic signed [WORD_BITS-1:0] r_v0 [3];
    logic [2*WORD_BITS-1:0]      r_sq [3];
    logic [SIDE_BITS-1:0]        r_s0, r_s1;
    logic signed [WORD_BITS-1:0] r_v1 [3];
    logic [SQ-1:0]               r_n;

    logic [SQ-1:0]               r_rn [WORD_BITS+1];
    logic [WORD_BITS-1:0]        r_rt [WORD_BITS+1];
    logic signed [WORD_BITS-1:0] r_rv [WORD_BITS+1][3];
    logic [SIDE_BITS-1:0]        r_rs [WORD_BITS+1];

    logic signed [WORD_BITS-1:0] r_dv [DEP+1][3];
    logic                        r_dz [DEP+1];
    logic [SIDE_BITS-1:0]        r_ds [DEP+1];
    logic signed [WORD_BITS-1:0] w_q  [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                r_v0[i] <= i_v[i];
                r_sq[i] <= (2*WORD_BITS)'($signed(i_v[i]) * $signed(i_v[i]));
                r_v1[i] <= r_v0[i];
            end
            r_s0 <= i_side;
            r_n  <= SQ'(r_sq[0]) + SQ'(r_sq[1]) + SQ'(r_sq[2]);
            r_s1 <= r_s0;
        end
    end

    always_comb begin
        r_rn[0] = r_n;
        r_rt[0] = '0;
        r_rv[0] = r_v1;
        r_rs[0] = r_s1;
    end

    // square root, one result bit per stage, msb first
    for (genvar b = 0; b < WORD_BITS; b++) begin : g_sq
        localparam int BIT = WORD_BITS - 1 - b;
        logic [WORD_BITS-1:0] w_c;
        logic [SQ-1:0]        w_cc;
        assign w_c  = r_rt[b] | (WORD_BITS'(1) << BIT);
        assign w_cc = SQ'(w_c) * SQ'(w_c);
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_rn[b+1] <= r_rn[b];
                r_rt[b+1] <= (w_cc <= r_rn[b]) ? w_c : r_rt[b];
                r_rv[b+1] <= r_rv[b];
                r_rs[b+1] <= r_rs[b];
            end
        end
    end

    for (genvar i = 0; i < 3; i++) begin : g_dv
        lav_div #(.WORD_BITS(WORD_BITS), .FRAC_BITS(FRAC_BITS)) u_div (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_v   (r_rv[WORD_BITS][i]),
            .i_s   (r_rt[WORD_BITS]),
            .o_q   (w_q[i])
        );
    end

    always_comb begin
        r_dv[0] = r_rv[WORD_BITS];
        r_dz[0] = (r_rn[WORD_BITS] == '0);
        r_ds[0] = r_rs[WORD_BITS];
    end

    for (genvar k = 0; k < DEP; k++) begin : g_dl
        always_ff @(posedge i_clk) begin
            if (i_en) begin
                r_dv[k+1] <= r_dv[k];
                r_dz[k+1] <= r_dz[k];
                r_ds[k+1] <= r_ds[k];
            end
        end
    end

    always_comb begin
        for (int i = 0; i < 3; i++) o_v[i] = r_dz[DEP] ? r_dv[DEP][i] : w_q[i];
        o_side = r_ds[DEP];
    end
endmodule

[rtl/lav_cross.sv]
// ---------------------------------------------------------------------------
// lav_cross
// Cross product or negated dot product in two stages: floored fixed-point
// products registered, then an exact sum saturated once to a word.
// ---------------------------------------------------------------------------
module lav_cross #(
    parameter int WORD_BITS = lav_pkg::WORD_BITS,
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS,
    parameter bit DOT       = 1'b0
) (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic signed [WORD_BITS-1:0] i_a [3],
    input  logic signed [WORD_BITS-1:0] i_b [3],
    output logic signed [WORD_BITS-1:0] o_c [3]
);
    localparam int PW = 2*WORD_BITS;
    localparam int SW = PW + 3;
    localparam logic signed [SW-1:0] MAXW = SW'((PW'(1) << (WORD_BITS-1)) - 1);
    localparam logic signed [SW-1:0] MINW = -MAXW - SW'(1);

    logic signed [PW-1:0] r_p [6];
    logic signed [SW-1:0] w_s [3];

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            if (DOT) begin
                for (int i = 0; i < 3; i++)
                    r_p[i] <= (i_a[i] * i_b[i]) >>> FRAC_BITS;
                for (int i = 3; i < 6; i++) r_p[i] <= '0;
            end else begin
                r_p[0] <= (i_a[1] * i_b[2]) >>> FRAC_BITS;
                r_p[1] <= (i_a[2] * i_b[1]) >>> FRAC_BITS;
                r_p[2] <= (i_a[2] * i_b[0]) >>> FRAC_BITS;
                r_p[3] <= (i_a[0] * i_b[2]) >>> FRAC_BITS;
                r_p[4] <= (i_a[0] * i_b[1]) >>> FRAC_BITS;
                r_p[5] <= (i_a[1] * i_b[0]) >>> FRAC_BITS;
            end
        end
    end

    always_comb begin
        if (DOT) begin
            w_s[0] = -(SW'(r_p[0]) + SW'(r_p[1]) + SW'(r_p[2]));
            w_s[1] = '0;
            w_s[2] = '0;
        end else begin
            w_s[0] = SW'(r_p[0]) - SW'(r_p[1]);
            w_s[1] = SW'(r_p[2]) - SW'(r_p[3]);
            w_s[2] = SW'(r_p[4]) - SW'(r_p[5]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int i = 0; i < 3; i++) begin
                if (w_s[i] > MAXW)      o_c[i] <= MAXW[WORD_BITS-1:0];
                else if (w_s[i] < MINW) o_c[i] <= MINW[WORD_BITS-1:0];
                else                    o_c[i] <= w_s[i][WORD_BITS-1:0];
            end
        end
    end
endmodule

[rtl/look_at_view_matrix.sv]
// ---------------------------------------------------------------------------
// look_at_view_matrix
// Camera view matrix from eye, target and up vectors, signed fixed point.
// ---------------------------------------------------------------------------
// Input channel (i_valid/o_ready) takes one word: eye, target and up.
// Output channel (o_valid/i_ready) returns four words, rows 0..3 of the view
// matrix; row 3 has o_last_row set. Rows 0..2 are (r, u, f, 0), row 3 is
// (-r.eye, -u.eye, -f.eye, 1.0), all saturated.
// The datapath is one long pipeline: difference, normalize f (square, root,
// divide), cross f x up, normalize r, cross r x f, dot products. Every
// stage advances together when the pipe may move.
// Throughput is set by the four-row serializer at the output; the pipe
// moves when the holding register is free or its last row is being taken,
// so back-to-back words keep the output busy every cycle.
// A receiver stall freezes the whole pipe; nothing is lost or repeated.
// Reset clears all valid bits and the serializer; payload holds no reset.
// ---------------------------------------------------------------------------
module look_at_view_matrix #(
    parameter int WORD_BITS = lav_pkg::WORD_BITS,
    parameter int FRAC_BITS = lav_pkg::FRAC_BITS
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_valid,
    output logic                        o_ready,
    input  logic signed [WORD_BITS-1:0] i_eye_x,
    input  logic signed [WORD_BITS-1:0] i_eye_y,
    input  logic signed [WORD_BITS-1:0] i_eye_z,
    input  logic signed [WORD_BITS-1:0] i_target_x,
    input  logic signed [WORD_BITS-1:0] i_target_y,
    input  logic signed [WORD_BITS-1:0] i_target_z,
    input  logic signed [WORD_BITS-1:0] i_up_x,
    input  logic signed [WORD_BITS-1:0] i_up_y,
    input  logic signed [WORD_BITS-1:0] i_up_z,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [1:0]                  o_row_index,
    output logic signed [WORD_BITS-1:0] o_col_x,
    output logic signed [WORD_BITS-1:0] o_col_y,
    output logic signed [WORD_BITS-1:0] o_col_z,
    output logic signed [WORD_BITS-1:0] o_col_w,
    output logic                        o_last_row
);
    localparam int W  = WORD_BITS;
    // normalize depth: square, sum, root bits, divider input and quotient bits
    localparam int NL = 2*W + FRAC_BITS + 3;
    localparam int LAT = 1 + NL + 2 + NL + 2 + 2;
    localparam logic signed [W:0] MAXW = (W+1)'((W+1)'(1) << (W-1)) - (W+1)'(1);
    localparam logic signed [W:0] MINW = -MAXW - (W+1)'(1);
    localparam int OW = W + FRAC_BITS + 2;
    localparam logic signed [OW-1:0] ONE_W = OW'(1) << FRAC_BITS;
    localparam logic signed [OW-1:0] MAXO  = OW'(MAXW);

    logic               w_en;
    logic [LAT-1:0]     r_vld;
    logic               r_full;
    logic [1:0]         r_row;

    // stage 0: difference
    logic signed [W-1:0] r_f0 [3];
    logic signed [W-1:0] r_e0 [3];
    logic signed [W-1:0] r_u0 [3];
    logic signed [W:0]   w_d  [3];

    assign w_d[0] = (W+1)'(i_target_x) - (W+1)'(i_eye_x);
    assign w_d[1] = (W+1)'(i_target_y) - (W+1)'(i_eye_y);
    assign w_d[2] = (W+1)'(i_target_z) - (W+1)'(i_eye_z);

    // holding register frees up on the edge that takes row 3
    assign w_en    = !r_full || (r_row == 2'd3 && i_ready);
    assign o_ready = w_en;

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                if (w_d[i] > MAXW)      r_f0[i] <= MAXW[W-1:0];
                else if (w_d[i] < MINW) r_f0[i] <= MINW[W-1:0];
                else                    r_f0[i] <= w_d[i][W-1:0];
            end
            r_e0 <= '{i_eye_x, i_eye_y, i_eye_z};
            r_u0 <= '{i_up_x, i_up_y, i_up_z};
        end
    end

    // normalize f, carrying eye and up
    logic signed [W-1:0] w_f1 [3];
    logic [6*W-1:0]      w_s1;
    logic signed [W-1:0] w_e1 [3];
    logic signed [W-1:0] w_u1 [3];

    lav_norm #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS), .SIDE_BITS(6*W)) u_nf (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_v    (r_f0),
        .i_side ({r_e0[0], r_e0[1], r_e0[2], r_u0[0], r_u0[1], r_u0[2]}),
        .o_v    (w_f1),
        .o_side (w_s1)
    );
    assign {w_e1[0], w_e1[1], w_e1[2], w_u1[0], w_u1[1], w_u1[2]} = w_s1;

    // r = f x up (2 stages), eye and f delayed alongside
    logic signed [W-1:0] w_r2 [3];
    logic signed [W-1:0] r_fa [2][3];
    logic signed [W-1:0] r_ea [2][3];

    lav_cross #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS), .DOT(1'b0)) u_cr (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_f1), .i_b (w_u1), .o_c (w_r2)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_fa[0] <= w_f1;  r_fa[1] <= r_fa[0];
            r_ea[0] <= w_e1;  r_ea[1] <= r_ea[0];
        end
    end

    // normalize r
    logic signed [W-1:0] w_r3 [3];
    logic [6*W-1:0]      w_s3;
    logic signed [W-1:0] w_f3 [3];
    logic signed [W-1:0] w_e3 [3];

    lav_norm #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS), .SIDE_BITS(6*W)) u_nr (
        .i_clk  (i_clk),
        .i_en   (w_en),
        .i_v    (w_r2),
        .i_side ({r_fa[1][0], r_fa[1][1], r_fa[1][2], r_ea[1][0], r_ea[1][1], r_ea[1][2]}),
        .o_v    (w_r3),
        .o_side (w_s3)
    );
    assign {w_f3[0], w_f3[1], w_f3[2], w_e3[0], w_e3[1], w_e3[2]} = w_s3;

    // u = r x f
    logic signed [W-1:0] w_u4 [3];
    logic signed [W-1:0] r_rb [2][3];
    logic signed [W-1:0] r_fb [2][3];
    logic signed [W-1:0] r_eb [2][3];

    lav_cross #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS), .DOT(1'b0)) u_cu (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_r3), .i_b (w_f3), .o_c (w_u4)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rb[0] <= w_r3; r_rb[1] <= r_rb[0];
            r_fb[0] <= w_f3; r_fb[1] <= r_fb[0];
            r_eb[0] <= w_e3; r_eb[1] <= r_eb[0];
        end
    end

    // row 3 dot products
    logic signed [W-1:0] w_dr [3];
    logic signed [W-1:0] w_du [3];
    logic signed [W-1:0] w_df [3];
    logic signed [W-1:0] r_rc [2][3];
    logic signed [W-1:0] r_uc [2][3];
    logic signed [W-1:0] r_fc [2][3];

    lav_cross #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS), .DOT(1'b1)) u_dr (
        .i_clk (i_clk), .i_en (w_en), .i_a (r_rb[1]), .i_b (r_eb[1]), .o_c (w_dr)
    );
    lav_cross #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS), .DOT(1'b1)) u_du (
        .i_clk (i_clk), .i_en (w_en), .i_a (w_u4), .i_b (r_eb[1]), .o_c (w_du)
    );
    lav_cross #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS), .DOT(1'b1)) u_df (
        .i_clk (i_clk), .i_en (w_en), .i_a (r_fb[1]), .i_b (r_eb[1]), .o_c (w_df)
    );

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_rc[0] <= r_rb[1]; r_rc[1] <= r_rc[0];
            r_uc[0] <= w_u4;    r_uc[1] <= r_uc[0];
            r_fc[0] <= r_fb[1]; r_fc[1] <= r_fc[0];
        end
    end

    // valid bits and four-row serializer
    logic signed [W-1:0] r_hr [3];
    logic signed [W-1:0] r_hu [3];
    logic signed [W-1:0] r_hf [3];
    logic signed [W-1:0] r_hd [3];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld  <= '0;
            r_full <= 1'b0;
            r_row  <= '0;
        end else begin
            if (w_en) r_vld <= {r_vld[LAT-2:0], i_valid};
            if (w_en && r_vld[LAT-1]) begin
                r_full <= 1'b1;
                r_row  <= '0;
            end else if (r_full && i_ready) begin
                r_row <= r_row + 2'd1;
                if (r_row == 2'd3) r_full <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en && r_vld[LAT-1]) begin
            r_hr <= r_rc[1];
            r_hu <= r_uc[1];
            r_hf <= r_fc[1];
            r_hd <= '{w_dr[0], w_du[0], w_df[0]};
        end
    end

    assign o_valid     = r_full;
    assign o_row_index = r_row;
    assign o_last_row  = (r_row == 2'd3);
    always_comb begin
        unique case (r_row)
            2'd3: begin
                o_col_x = r_hd[0];
                o_col_y = r_hd[1];
                o_col_z = r_hd[2];
                o_col_w = (ONE_W > MAXO) ? MAXW[W-1:0] : ONE_W[W-1:0];
            end
            default: begin
                o_col_x = r_hr[r_row];
                o_col_y = r_hu[r_row];
                o_col_z = r_hf[r_row];
                o_col_w = '0;
            end
        endcase
    end

    a_last_only_row3: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_last_row == (o_row_index == 2'd3)))
        else $error("last_row flag mismatch");
    a_hold_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !i_ready) |=>
        (o_valid && $stable(o_row_index) && $stable(o_col_x)))
        else $error("output word changed while stalled");
    a_row_advance: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && i_ready && o_row_index != 2'd3) |=>
        (o_valid && o_row_index == $past(o_row_index) + 2'd1))
        else $error("row sequence broken");
endmodule

[tb/sv/tb_look_at_view_matrix.sv]
`timescale 1ns / 100ps
// ---------------------------------------------------------------------------
// tb_look_at_view_matrix
// Self-checking bench for the look-at view matrix block. Each eye/target/up
// word is predicted in fixed point and the four expected rows are queued and
// compared in order against the output channel under random flow control.
// ---------------------------------------------------------------------------
module tb_look_at_view_matrix;

    localparam int W = lav_pkg::WORD_BITS;
    localparam int F = lav_pkg::FRAC_BITS;
    localparam int LATENCY = 4 * W + 2 * F + 13;
    localparam int STALL_LIMIT = 20 * LATENCY + 2000;

    typedef logic signed [W-1:0] t_word;
    typedef logic signed [255:0] t_acc;

    typedef struct packed {
        logic [1:0] row;
        t_word      cx;
        t_word      cy;
        t_word      cz;
        t_word      cw;
        logic       last;
    } t_row;

    logic  i_clk = 1'b0;
    logic  i_rst_n = 1'b0;
    logic  i_valid = 1'b0;
    logic  o_ready;
    t_word i_eye_x = '0, i_eye_y = '0, i_eye_z = '0;
    t_word i_target_x = '0, i_target_y = '0, i_target_z = '0;
    t_word i_up_x = '0, i_up_y = '0, i_up_z = '0;
    logic  o_valid;
    logic  i_ready = 1'b0;
    logic [1:0] o_row_index;
    t_word o_col_x, o_col_y, o_col_z, o_col_w;
    logic  o_last_row;

    t_row  rows_due[$];
    int    err_cnt = 0;
    int    words_sent = 0;
    int    rows_seen = 0;
    int    idle_cycles = 0;
    bit    done = 1'b0;
    int    burst_left = 0;

    always #1 i_clk = ~i_clk;

    look_at_view_matrix u_dut (.*);

    // ---- fixed-point predictor --------------------------------------------
    function automatic t_word sat_word(t_acc a);
        t_acc hi, lo;
        hi = (t_acc'(1) <<< (W - 1)) - 1;
        lo = -hi - 1;
        if (a > hi) return t_word'(hi);
        if (a < lo) return t_word'(lo);
        return t_word'(a);
    endfunction

    // exact product, floored by the fraction shift
    function automatic t_acc qmul(t_word a, t_word b);
        t_acc p;
        p = t_acc'(a) * t_acc'(b);
        return p >>> F;
    endfunction

    function automatic void normalize_vec(ref t_word v[3]);
        logic [255:0] n, s, c, q, m;
        n = 0;
        for (int i = 0; i < 3; i++) begin
            m = (v[i] < 0) ? -t_acc'(v[i]) : t_acc'(v[i]);
            n += m * m;
        end
        if (n == 0) return;
        s = 0;
        for (int b = 63; b >= 0; b--) begin
            c = s | (256'd1 << b);
            if (c * c <= n) s = c;
        end
        for (int i = 0; i < 3; i++) begin
            m = (v[i] < 0) ? -t_acc'(v[i]) : t_acc'(v[i]);
            q = (m << F) / s;
            v[i] = sat_word((v[i] < 0) ? -t_acc'(q) : t_acc'(q));
        end
    endfunction

    function automatic void cross_vec(t_word a[3], t_word b[3], ref t_word o[3]);
        o[0] = sat_word(qmul(a[1], b[2]) - qmul(a[2], b[1]));
        o[1] = sat_word(qmul(a[2], b[0]) - qmul(a[0], b[2]));
        o[2] = sat_word(qmul(a[0], b[1]) - qmul(a[1], b[0]));
    endfunction

    function automatic t_word neg_dot(t_word a[3], t_word b[3]);
        return sat_word(-(qmul(a[0], b[0]) + qmul(a[1], b[1]) + qmul(a[2], b[2])));
    endfunction

    task automatic predict_view(t_word eye[3], t_word tgt[3], t_word up[3]);
        t_word f[3], r[3], u[3];
        t_row  e;
        for (int i = 0; i < 3; i++) f[i] = sat_word(t_acc'(tgt[i]) - t_acc'(eye[i]));
        normalize_vec(f);
        cross_vec(f, up, r);
        normalize_vec(r);
        cross_vec(r, f, u);
        for (int i = 0; i < 3; i++) begin
            e = '{row: 2'(i), cx: r[i], cy: u[i], cz: f[i], cw: '0, last: 1'b0};
            rows_due.push_back(e);
        end
        e = '{row: 2'd3, cx: neg_dot(r, eye), cy: neg_dot(u, eye), cz: neg_dot(f, eye),
              cw: sat_word(t_acc'(1) <<< F), last: 1'b1};
        rows_due.push_back(e);
    endtask

    // ---- send one word ----------------------------------------------------
    task automatic send_view(t_word eye[3], t_word tgt[3], t_word up[3]);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 12);
            gap = ($urandom_range(0, 2) == 0) ? $urandom_range(1, 10) : 0;
            if (gap > 0) begin
                i_valid <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
        end
        burst_left--;
        i_valid    <= 1'b1;
        i_eye_x    <= eye[0]; i_eye_y    <= eye[1]; i_eye_z    <= eye[2];
        i_target_x <= tgt[0]; i_target_y <= tgt[1]; i_target_z <= tgt[2];
        i_up_x     <= up[0];  i_up_y     <= up[1];  i_up_z     <= up[2];
        predict_view(eye, tgt, up);
        do @(posedge i_clk); while (!o_ready);
        words_sent++;
    endtask

    // drop valid and wait until every queued row has come out
    task automatic pause_sender();
        i_valid <= 1'b0;
        @(posedge i_clk);
        wait (rows_due.size() == 0);
    endtask

    function automatic t_word rand_word();
        case ($urandom_range(0, 5))
            0: return t_word'($urandom);
            1: return t_word'($urandom_range(0, 4) << F) * ($urandom_range(0, 1) ? 1 : -1);
            2: return {1'b1, {(W-1){1'b0}}};
            3: return {1'b0, {(W-1){1'b1}}};
            default: return t_word'($signed($urandom_range(0, 32'h0010_0000)) - 32'sh8_0000);
        endcase
    endfunction

    // ---- output side: receiver stall pattern and checker ------------------
    int stall_phase = 0;
    always @(posedge i_clk) begin
        stall_phase <= stall_phase + 1;
        i_ready <= ((stall_phase / 64) % 3 == 0) ? 1'b1 : ($urandom_range(0, 3) != 0);
    end

    task automatic report_mismatch(string what, t_word got, t_word want);
        $display("tb: mismatch %s got %h want %h", what, got, want);
        err_cnt++;
    endtask

    always @(posedge i_clk) begin
        t_row e;
        if (i_rst_n && o_valid && i_ready) begin
            rows_seen++;
            if (rows_due.size() == 0) begin
                report_mismatch("unexpected row", t_word'(o_row_index), '0);
            end else begin
                e = rows_due.pop_front();
                if (o_row_index != e.row)
                    report_mismatch("row_index", t_word'(o_row_index), t_word'(e.row));
                if (o_col_x != e.cx) report_mismatch("col_x", o_col_x, e.cx);
                if (o_col_y != e.cy) report_mismatch("col_y", o_col_y, e.cy);
                if (o_col_z != e.cz) report_mismatch("col_z", o_col_z, e.cz);
                if (o_col_w != e.cw) report_mismatch("col_w", o_col_w, e.cw);
                if (o_last_row != e.last)
                    report_mismatch("last_row", t_word'(o_last_row), t_word'(e.last));
            end
        end
    end

    // watchdog: cycles with no word accepted on either side
    always @(posedge i_clk) begin
        if ((i_valid && o_ready) || (o_valid && i_ready) || done) idle_cycles <= 0;
        else idle_cycles <= idle_cycles + 1;
        if (idle_cycles > STALL_LIMIT) begin
            $display("tb: failure");
            $finish;
        end
    end

    // ---- tests ------------------------------------------------------------
    task automatic test_directed();
        t_word one, mx, mn, z[3], e[3], t[3], u[3];
        one = t_word'(1 << F);
        mx = {1'b0, {(W-1){1'b1}}};
        mn = {1'b1, {(W-1){1'b0}}};
        z = '{0, 0, 0};
        // basic camera on the +z axis, looking down -z
        e = '{0, 0, 5 * one}; t = '{0, 0, 0}; u = '{0, one, 0};
        send_view(e, t, u);
        // zero-length forward vector
        send_view(e, e, u);
        // up parallel to forward: degenerate right vector
        send_view(z, '{0, one, 0}, '{0, one, 0});
        // zero up vector
        send_view(e, t, z);
        // saturating differences and products
        send_view('{mn, mn, mn}, '{mx, mx, mx}, '{mx, mn, mx});
        send_view('{mx, mx, mx}, '{mn, mn, mn}, '{mn, mn, mn});
        send_view('{mx, mn, mx}, '{0, 0, 0}, '{one, 0, 0});
        send_view('{-1, -1, -1}, '{1, 1, 1}, '{-1, 1, -1});
        send_view('{mx, mx, mx}, '{mx, mx - one, mx}, '{0, 0, one});
        send_view('{mn, 0, mn}, '{mn, one, mn}, '{mx, 0, 0});
        // all-ones and alternating-bit patterns
        send_view('{'1, '1, '1}, '{'1, '1, '1}, '{'1, '1, '1});
        send_view('{32'h5555_5555, 32'hAAAA_AAAA, 32'h5555_5555},
                  '{32'hAAAA_AAAA, 32'h5555_5555, 32'hAAAA_AAAA},
                  '{32'h5555_5555, 32'h5555_5555, 32'hAAAA_AAAA});
    endtask

    task automatic test_random(int count);
        t_word e[3], t[3], u[3];
        for (int n = 0; n < count; n++) begin
            for (int i = 0; i < 3; i++) begin
                e[i] = rand_word(); t[i] = rand_word(); u[i] = rand_word();
            end
            send_view(e, t, u);
            // let the pipe drain once, mid-run
            if (n == count / 2) pause_sender();
        end
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_directed();
        test_random(418);
        pause_sender();
        done = 1'b1;
        repeat (LATENCY + 20) @(posedge i_clk);
        $display("tb: %0d view words sent, %0d matrix rows checked", words_sent, rows_seen);
        $display("tb: covered zero-length, degenerate-up and saturation cases");
        if (err_cnt == 0 && rows_due.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end

endmodule
